// ===== hdl/msq_pkg.sv =====
// msq_pkg: shared types and constants of the min/max short quantizer.
// No dependencies; imported by the interfaces and every module.
`default_nettype none

package msq_pkg;

   localparam int CMD_W     = 2;
   localparam int SAMPLE_W  = 32;
   localparam int RES_W     = 16;
   localparam int SPAN_W    = 32;
   localparam int SUM_W     = 32;
   localparam int FILL_W    = 16;
   localparam int LEVEL_W   = 16;
   localparam int QUOT_BITS = 16;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PACK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic signed [FILL_W-1:0] FILL_RESET = -16'sd32767;

   typedef struct packed {
      logic load;
      logic clear;
      logic pack;
      logic diff;
      logic mult;
      logic div_init;
      logic div_step;
      logic out_load;
   } msq_cmd_type;

   typedef struct packed {
      logic quick;
   } msq_status_type;

endpackage

`default_nettype wire

// ===== hdl/msq_if.sv =====
// msq_if: valid/ready channel interfaces for requests and results.
// Depends on msq_pkg for the field widths.
`default_nettype none

interface msq_req_if import msq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           cmd;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       valid_mask;

   modport source (output valid, cmd, sample, valid_mask, input ready);
   modport sink   (input valid, cmd, sample, valid_mask, output ready);
endinterface

interface msq_rsp_if import msq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [RES_W-1:0]  packed_res;
   logic                     status;
   logic                     is_last;
   logic [SPAN_W-1:0]        value_span;
   logic signed [SUM_W-1:0]  value_sum;

   modport source (output valid, packed_res, status, is_last, value_span, value_sum,
                   input ready);
   modport sink   (input valid, packed_res, status, is_last, value_span, value_sum,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/msq_ctrl.sv =====
// msq_ctrl: sequencer of the quantizer; decodes requests and steps the datapath.
// Depends on msq_pkg (command codes, command and status structs).
`default_nettype none

module msq_ctrl import msq_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic [CMD_W-1:0] req_cmd,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output msq_cmd_type         cmd_o,
   input  wire msq_status_type status_i
);

   localparam int CNT_W = $clog2(QUOT_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MULT,
      ST_INIT,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd_o        = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_LOAD:  cmd_o.load  = 1'b1;
                  CMD_CLEAR: cmd_o.clear = 1'b1;
                  CMD_PACK: begin
                     cmd_o.pack = 1'b1;
                     state_in   = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            cmd_o.diff = 1'b1;
            state_in   = status_i.quick ? ST_OUT : ST_MULT;
         end
         ST_MULT: begin
            cmd_o.mult = 1'b1;
            state_in   = ST_INIT;
         end
         ST_INIT: begin
            cmd_o.div_init = 1'b1;
            cnt_in         = CNT_W'(QUOT_BITS - 1);
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            cmd_o.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd_o.out_load = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd_o))
      else $error("more than one datapath command");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd_o.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   a_div_follows_init: assert property (@(posedge clock) disable iff (reset)
      cmd_o.div_init |=> cmd_o.div_step)
      else $error("divider init not followed by a step");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd_o.out_load |=> rsp_valid)
      else $error("loaded result not presented");

   a_busy_after_pack: assert property (@(posedge clock) disable iff (reset)
      cmd_o.pack |=> !req_ready)
      else $error("new request taken during pack");

endmodule

`default_nettype wire

// ===== hdl/msq_datapath.sv =====
// msq_datapath: sample store, running extremes, multiplier, 16-step divider
// and result register. Depends on msq_pkg; driven by msq_ctrl commands.
`default_nettype none

module msq_datapath import msq_pkg::*; #(
   parameter int DEPTH       = 4096,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire msq_cmd_type                cmd_i,
   output msq_status_type                  status_o,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_valid_mask,
   input  wire logic                       csr_wr_en,
   input  wire logic [FILL_W-1:0]          csr_wr_data,
   output logic signed [RES_W-1:0]         rsp_packed_res,
   output logic                            rsp_status,
   output logic                            rsp_is_last,
   output logic [SPAN_W-1:0]               rsp_value_span,
   output logic signed [SUM_W-1:0]         rsp_value_sum
);

   localparam int SB = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = SB + 2;
   localparam int MW = LEVEL_W + DW;
   localparam int NW = MW + 1;
   localparam int VW = SB + 1;

   // store entry: {mask, sample}
   logic [SB:0] mem [DEPTH];
   logic [SB:0] rd_ff;

   logic [CW-1:0]              count_ff, count_in, rptr_ff, rptr_in;
   logic signed [SB-1:0]       min_ff, min_in, max_ff, max_in;
   logic signed [FILL_W-1:0]   fill_ff, fill_in;
   logic                       empty_ff, empty_in, last_ff, last_in;
   logic [DW-1:0]              dmag_ff, dmag_in;
   logic                       neg_ff, neg_in;
   logic [MW-1:0]              prod_ff, prod_in;
   logic [VW-1:0]              rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QUOT_BITS-1:0]       nlow_ff, nlow_in, quot_ff, quot_in;
   logic signed [RES_W-1:0]    res_ff, res_in;
   logic                       stat_ff, stat_in, is_last_ff, is_last_in;
   logic [SPAN_W-1:0]          span_out_ff, span_out_in;
   logic signed [SUM_W-1:0]    sum_out_ff, sum_out_in;

   logic signed [SB-1:0]       x_new, x_rd, sum;
   logic [SB-1:0]              span;
   logic                       full;
   logic signed [LEVEL_W-1:0]  levels;
   logic [LEVEL_W-1:0]         lev_mag;
   logic signed [DW-1:0]       x_ext, sum_ext, diff;
   logic [NW-1:0]              numer, nshift;
   logic [VW:0]                trial, tsub;
   logic [RES_W-1:0]           qres;
   logic [CW-1:0]              rptr_next;

   assign x_new   = signed'(req_sample[SB-1:0]);
   assign x_rd    = signed'(rd_ff[SB-1:0]);
   assign full    = (count_ff == CW'(DEPTH));
   assign span    = SB'(max_ff - min_ff);
   assign sum     = max_ff + min_ff;
   assign levels  = (fill_ff < 0) ? (fill_ff + 16'sd2) : (fill_ff - 16'sd2);
   assign lev_mag = levels[LEVEL_W-1] ? LEVEL_W'(-levels) : LEVEL_W'(levels);
   assign x_ext   = DW'(x_rd);
   assign sum_ext = DW'(sum);
   assign diff    = (x_ext <<< 1) - sum_ext;
   assign numer   = NW'(prod_ff) + NW'(span);
   assign nshift  = numer >> QUOT_BITS;
   assign trial   = {rem_ff, nlow_ff[QUOT_BITS-1]};
   assign tsub    = trial - {1'b0, dvs_ff};
   assign qres    = neg_ff ? RES_W'(-quot_ff) : RES_W'(quot_ff);
   assign rptr_next = rptr_ff + 1'b1;

   assign status_o.quick = empty_ff | ~rd_ff[SB] | (span == '0);

   always_comb begin
      count_in    = count_ff;
      rptr_in     = rptr_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      fill_in     = csr_wr_en ? signed'(csr_wr_data) : fill_ff;
      empty_in    = empty_ff;
      last_in     = last_ff;
      dmag_in     = dmag_ff;
      neg_in      = neg_ff;
      prod_in     = prod_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      nlow_in     = nlow_ff;
      quot_in     = quot_ff;
      res_in      = res_ff;
      stat_in     = stat_ff;
      is_last_in  = is_last_ff;
      span_out_in = span_out_ff;
      sum_out_in  = sum_out_ff;

      if (cmd_i.load && !full) begin
         count_in = count_ff + 1'b1;
         if (req_valid_mask) begin
            if (x_new > max_ff) max_in = x_new;
            if (x_new < min_ff) min_in = x_new;
         end
      end
      if (cmd_i.clear) begin
         count_in = '0;
         rptr_in  = '0;
         min_in   = '0;
         max_in   = '0;
      end
      if (cmd_i.pack) begin
         empty_in = (rptr_ff >= count_ff);
         last_in  = 1'b0;
         if (rptr_ff < count_ff) begin
            rptr_in = rptr_next;
            last_in = (rptr_next == count_ff);
         end
      end
      if (cmd_i.diff) begin
         dmag_in = diff[DW-1] ? DW'(-diff) : DW'(diff);
         neg_in  = levels[LEVEL_W-1] ^ diff[DW-1];
      end
      if (cmd_i.mult) begin
         prod_in = MW'(lev_mag) * MW'(dmag_ff);
      end
      if (cmd_i.div_init) begin
         // (mag + span) / (2 span); quotient fits QUOT_BITS
         rem_in  = nshift[VW-1:0];
         nlow_in = numer[QUOT_BITS-1:0];
         dvs_in  = {span, 1'b0};
         quot_in = '0;
      end
      if (cmd_i.div_step) begin
         nlow_in = nlow_ff << 1;
         if (!tsub[VW]) begin
            rem_in  = tsub[VW-1:0];
            quot_in = {quot_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial[VW-1:0];
            quot_in = {quot_ff[QUOT_BITS-2:0], 1'b0};
         end
      end
      if (cmd_i.out_load) begin
         if (empty_ff) begin
            res_in = '0;
         end else if (!rd_ff[SB]) begin
            res_in = fill_ff;
         end else if (span == '0) begin
            res_in = '0;
         end else begin
            res_in = signed'(qres);
         end
         stat_in     = empty_ff;
         is_last_in  = last_ff;
         span_out_in = SPAN_W'(span);
         sum_out_in  = SUM_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rptr_ff  <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         fill_ff  <= FILL_RESET;
      end else begin
         count_ff <= count_in;
         rptr_ff  <= rptr_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      empty_ff    <= empty_in;
      last_ff     <= last_in;
      dmag_ff     <= dmag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      nlow_ff     <= nlow_in;
      quot_ff     <= quot_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
      is_last_ff  <= is_last_in;
      span_out_ff <= span_out_in;
      sum_out_ff  <= sum_out_in;
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load && !full) begin
         mem[count_ff[AW-1:0]] <= {req_valid_mask, req_sample[SB-1:0]};
      end
      if (cmd_i.pack) begin
         rd_ff <= mem[rptr_ff[AW-1:0]];
      end
   end

   assign rsp_packed_res = res_ff;
   assign rsp_status     = stat_ff;
   assign rsp_is_last    = is_last_ff;
   assign rsp_value_span = span_out_ff;
   assign rsp_value_sum  = sum_out_ff;

endmodule

`default_nettype wire

// ===== hdl/minmax_short_quantizer.sv =====
// minmax_short_quantizer: top level; joins msq_ctrl and msq_datapath.
// Depends on msq_pkg and the channel interfaces in msq_if.
//
//   port      | role        | handshake         | carries
//   req_bus   | request in  | valid/ready       | cmd, sample, valid_mask
//   rsp_bus   | result out  | valid/ready       | packed_res, status, is_last, span, sum
//   csr_wr_*  | config in   | write enable      | fill_value
//
// Load, clear and unused codes are taken back to back while idle.
// A pack steps from read straight to output when empty, masked out or at zero span,
// else through multiply, divider init and the 16-step restoring divider.
// Synchronous reset zeroes counts and extremes and sets fill_value to -32767;
// the store is not cleared.
// A pack result waits in the output register; loads and clears still proceed.
`default_nettype none

module minmax_short_quantizer import msq_pkg::*; #(
   parameter int DEPTH       = 4096,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   msq_req_if.sink                req_bus,
   msq_rsp_if.source              rsp_bus,
   input  wire logic              csr_wr_en,
   input  wire logic [FILL_W-1:0] csr_wr_data
);

   msq_cmd_type    dp_cmd;
   msq_status_type dp_status;

   msq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd_o     (dp_cmd),
      .status_i  (dp_status)
   );

   msq_datapath #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd_i          (dp_cmd),
      .status_o       (dp_status),
      .req_sample     (req_bus.sample),
      .req_valid_mask (req_bus.valid_mask),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_packed_res (rsp_bus.packed_res),
      .rsp_status     (rsp_bus.status),
      .rsp_is_last    (rsp_bus.is_last),
      .rsp_value_span (rsp_bus.value_span),
      .rsp_value_sum  (rsp_bus.value_sum)
   );

endmodule

`default_nettype wire
